### rtl/line_from_two_points_canonical_core_defines.svh
// Assertion helpers for the line core.
// Each macro expects i_clk and i_rst_n in the enclosing module.
`ifndef LINE_FROM_TWO_POINTS_CANONICAL_CORE_DEFINES_SVH
`define LINE_FROM_TWO_POINTS_CANONICAL_CORE_DEFINES_SVH

// Same-cycle implication
`define LFTP_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("line core: same-cycle check failed");

// Next-cycle implication
`define LFTP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("line core: next-cycle check failed");

`endif

### rtl/lftp_pkg.sv
package lftp_pkg;

    // Coordinate width and derived widths
    localparam int COORD_BITS = 16;
    localparam int A_W        = COORD_BITS;          // normalized a, unsigned
    localparam int B_W        = COORD_BITS + 1;      // signed a, b and normalized b
    localparam int C_W        = 2 * COORD_BITS + 1;  // signed c
    localparam int MAG_W      = 2 * COORD_BITS;      // magnitude of any coefficient
    localparam int CNT_W      = $clog2(MAG_W);       // divider step counter
    localparam int K_W        = $clog2(MAG_W + 1);   // common power-of-two count

    // Controller to datapath commands
    typedef struct packed {
        logic load;       // capture differences, products, start gcd(|a|,|b|)
        logic calc_c;     // form c from the registered products
        logic gcd_step;   // one binary gcd step
        logic gcd_init2;  // start gcd(g1,|c|)
        logic div_init;   // latch divisor, seed the three dividers
        logic div_step;   // one restoring divide step on all lanes
        logic finish;     // load the output register
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic gcd_done;
        logic gcd_zero;
        logic div_last;
    } t_dp_sts;

    // One restoring divider lane
    typedef struct packed {
        logic [MAG_W:0]   rem;
        logic [MAG_W-1:0] quo;
    } t_div_lane;

endpackage

### rtl/lftp_ctrl.sv
module lftp_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    input  lftp_pkg::t_dp_sts i_sts,
    output lftp_pkg::t_dp_cmd o_cmd
);
    import lftp_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PROD,
        S_GCD_AB,
        S_GCD_C,
        S_DIV,
        S_DONE
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign out_free    = !r_out_valid || i_out_ready;

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_PROD;
                end
            end
            S_PROD: begin
                o_cmd.calc_c = 1'b1;
                n_state      = S_GCD_AB;
            end
            S_GCD_AB: begin
                if (i_sts.gcd_done) begin
                    o_cmd.gcd_init2 = 1'b1;
                    n_state         = S_GCD_C;
                end else begin
                    o_cmd.gcd_step = 1'b1;
                end
            end
            S_GCD_C: begin
                if (i_sts.gcd_done) begin
                    o_cmd.div_init = 1'b1;
                    n_state        = i_sts.gcd_zero ? S_DONE : S_DIV;
                end else begin
                    o_cmd.gcd_step = 1'b1;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Output valid: set on finish, cleared when taken
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.finish) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

### rtl/lftp_dp.sv
module lftp_dp (
    input  logic                                 i_clk,
    input  lftp_pkg::t_dp_cmd                    i_cmd,
    output lftp_pkg::t_dp_sts                    o_sts,
    input  logic signed [lftp_pkg::COORD_BITS-1:0] i_first_x,
    input  logic signed [lftp_pkg::COORD_BITS-1:0] i_first_y,
    input  logic signed [lftp_pkg::COORD_BITS-1:0] i_second_x,
    input  logic signed [lftp_pkg::COORD_BITS-1:0] i_second_y,
    output logic        [lftp_pkg::A_W-1:0]      o_line_a,
    output logic signed [lftp_pkg::B_W-1:0]      o_line_b,
    output logic signed [lftp_pkg::C_W-1:0]      o_line_c,
    output logic                                 o_degenerate
);
    import lftp_pkg::*;

    // Magnitude of a signed a or b, zero-extended
    function automatic logic [MAG_W-1:0] mag_ab(input logic signed [B_W-1:0] v);
        logic [B_W-1:0] m;
        m = v[B_W-1] ? B_W'(-v) : B_W'(v);
        return MAG_W'(m);
    endfunction

    // Magnitude of c; always fits MAG_W bits
    function automatic logic [MAG_W-1:0] mag_c(input logic signed [C_W-1:0] v);
        logic [C_W-1:0] m;
        m = v[C_W-1] ? C_W'(-v) : C_W'(v);
        return m[MAG_W-1:0];
    endfunction

    // One restoring division step
    function automatic t_div_lane div_lane(input t_div_lane l, input logic [MAG_W-1:0] d);
        logic [MAG_W:0]   sh;
        logic [MAG_W+1:0] diff;
        t_div_lane        o;
        sh    = {l.rem[MAG_W-1:0], l.quo[MAG_W-1]};
        diff  = {1'b0, sh} - {2'b00, d};
        o.quo = {l.quo[MAG_W-2:0], ~diff[MAG_W+1]};
        o.rem = diff[MAG_W+1] ? sh : diff[MAG_W:0];
        return o;
    endfunction

    logic signed [B_W-1:0]     r_a, r_b;
    logic signed [MAG_W-1:0]   r_p1, r_p2;
    logic signed [C_W-1:0]     r_c;
    logic [MAG_W-1:0]          r_u, r_v;
    logic [K_W-1:0]            r_k;
    logic [MAG_W-1:0]          r_g;
    logic                      r_deg;
    logic [CNT_W-1:0]          r_cnt;
    t_div_lane                 r_la, r_lb, r_lc;

    logic signed [B_W-1:0]     a_in, b_in;
    logic signed [MAG_W-1:0]   p1_in, p2_in;
    logic [MAG_W-1:0]          gcd_res;
    logic                      flip;
    logic [B_W-1:0]            qb_mag;
    logic [C_W-1:0]            qc_mag;
    logic signed [B_W-1:0]     b_val;
    logic signed [C_W-1:0]     c_val;

    // Input differences and cross products
    assign a_in  = B_W'(i_first_y) - B_W'(i_second_y);
    assign b_in  = B_W'(i_second_x) - B_W'(i_first_x);
    assign p1_in = i_first_x * i_second_y;
    assign p2_in = i_second_x * i_first_y;

    // gcd result once one operand reaches zero
    assign gcd_res = (r_u | r_v) << r_k;

    assign o_sts.gcd_done = (r_u == '0) || (r_v == '0);
    assign o_sts.gcd_zero = (gcd_res == '0);
    assign o_sts.div_last = (r_cnt == CNT_W'(MAG_W - 1));

    // Capture differences and products, form c
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_a  <= a_in;
            r_b  <= b_in;
            r_p1 <= p1_in;
            r_p2 <= p2_in;
        end
        if (i_cmd.calc_c) begin
            r_c <= C_W'(r_p1) - C_W'(r_p2);
        end
    end

    // Binary gcd, one step per cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_u <= mag_ab(a_in);
            r_v <= mag_ab(b_in);
            r_k <= '0;
        end else if (i_cmd.gcd_init2) begin
            r_u <= gcd_res;
            r_v <= mag_c(r_c);
            r_k <= '0;
        end else if (i_cmd.gcd_step) begin
            if (!r_u[0] && !r_v[0]) begin
                r_u <= r_u >> 1;
                r_v <= r_v >> 1;
                r_k <= r_k + 1'b1;
            end else if (!r_u[0]) begin
                r_u <= r_u >> 1;
            end else if (!r_v[0]) begin
                r_v <= r_v >> 1;
            end else if (r_u >= r_v) begin
                r_u <= r_u - r_v;
            end else begin
                r_v <= r_v - r_u;
            end
        end
    end

    // Three exact divisions by the gcd, in lockstep
    always_ff @(posedge i_clk) begin
        if (i_cmd.div_init) begin
            r_g      <= gcd_res;
            r_deg    <= (gcd_res == '0);
            r_cnt    <= '0;
            r_la.rem <= '0;
            r_lb.rem <= '0;
            r_lc.rem <= '0;
            r_la.quo <= mag_ab(r_a);
            r_lb.quo <= mag_ab(r_b);
            r_lc.quo <= mag_c(r_c);
        end else if (i_cmd.div_step) begin
            r_cnt <= r_cnt + 1'b1;
            r_la  <= div_lane(r_la, r_g);
            r_lb  <= div_lane(r_lb, r_g);
            r_lc  <= div_lane(r_lc, r_g);
        end
    end

    // Sign fix-up: first nonzero of (a, b) ends positive
    assign flip   = r_a[B_W-1] || ((r_a == '0) && r_b[B_W-1]);
    assign qb_mag = r_lb.quo[B_W-1:0];
    assign qc_mag = C_W'(r_lc.quo);
    assign b_val  = (r_b[B_W-1] ^ flip) ? B_W'(-qb_mag) : B_W'(qb_mag);
    assign c_val  = (r_c[C_W-1] ^ flip) ? C_W'(-qc_mag) : C_W'(qc_mag);

    // Output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            o_degenerate <= r_deg;
            if (r_deg) begin
                o_line_a <= '0;
                o_line_b <= '0;
                o_line_c <= '0;
            end else begin
                o_line_a <= r_la.quo[A_W-1:0];
                o_line_b <= b_val;
                o_line_c <= c_val;
            end
        end
    end

endmodule

### rtl/line_from_two_points_canonical_core.sv
// Per accepted item: c is formed from the products, a binary gcd of |a| and |b| runs, then a gcd
//   of that result with |c|, then a restoring division of a, b and c by the gcd, then the output
//   load; coincident points skip the division.
// Throughput: one item at a time; the next item is accepted the cycle after the output load.
//   A result waiting in the output register holds only the next output load.
//   Reset: synchronous active-low i_rst_n clears state/valid.
`include "line_from_two_points_canonical_core_defines.svh"

module line_from_two_points_canonical_core (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_in_valid,
    output logic                                   o_in_ready,
    input  logic signed [lftp_pkg::COORD_BITS-1:0] i_first_x,
    input  logic signed [lftp_pkg::COORD_BITS-1:0] i_first_y,
    input  logic signed [lftp_pkg::COORD_BITS-1:0] i_second_x,
    input  logic signed [lftp_pkg::COORD_BITS-1:0] i_second_y,
    output logic                                   o_out_valid,
    input  logic                                   i_out_ready,
    output logic        [lftp_pkg::A_W-1:0]        o_line_a,
    output logic signed [lftp_pkg::B_W-1:0]        o_line_b,
    output logic signed [lftp_pkg::C_W-1:0]        o_line_c,
    output logic                                   o_degenerate
);
    import lftp_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    // Sequencer
    lftp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // Arithmetic
    lftp_dp u_dp (
        .i_clk        (i_clk),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_first_x    (i_first_x),
        .i_first_y    (i_first_y),
        .i_second_x   (i_second_x),
        .i_second_y   (i_second_y),
        .o_line_a     (o_line_a),
        .o_line_b     (o_line_b),
        .o_line_c     (o_line_c),
        .o_degenerate (o_degenerate)
    );

    // Degenerate results carry zero coefficients
    `LFTP_ASSERT_SAME(a_deg_zero, o_out_valid && o_degenerate,
        (o_line_a == '0) && (o_line_b == '0) && (o_line_c == '0))

    // Canonical sign: a nonzero, or a zero with b positive
    `LFTP_ASSERT_SAME(a_canon_sign, o_out_valid && !o_degenerate,
        (o_line_a != '0) || (!o_line_b[B_W-1] && (o_line_b != '0)))

    // An accepted item keeps the input closed the next cycle
    `LFTP_ASSERT_NEXT(a_busy_after_accept, i_in_valid && o_in_ready, !o_in_ready)

endmodule

### bench/line_canon_checker.sv
`timescale 1ns / 100ps

module line_canon_checker (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_in_valid,
    input  logic                                   i_in_ready,
    input  logic signed [lftp_pkg::COORD_BITS-1:0] i_first_x,
    input  logic signed [lftp_pkg::COORD_BITS-1:0] i_first_y,
    input  logic signed [lftp_pkg::COORD_BITS-1:0] i_second_x,
    input  logic signed [lftp_pkg::COORD_BITS-1:0] i_second_y,
    input  logic                                   i_out_valid,
    input  logic                                   i_out_ready,
    input  logic        [lftp_pkg::A_W-1:0]        i_line_a,
    input  logic signed [lftp_pkg::B_W-1:0]        i_line_b,
    input  logic signed [lftp_pkg::C_W-1:0]        i_line_c,
    input  logic                                   i_degenerate,
    output int                                     o_fail_count,
    output int                                     o_pending
);
    import lftp_pkg::*;

    localparam int CW = COORD_BITS;

    // One canonical line, with the points it came from for messages
    typedef struct packed {
        logic signed [CW-1:0]  x1;
        logic signed [CW-1:0]  y1;
        logic signed [CW-1:0]  x2;
        logic signed [CW-1:0]  y2;
        logic        [A_W-1:0] a;
        logic signed [B_W-1:0] b;
        logic signed [C_W-1:0] c;
        logic                  degen;
    } t_line;

    t_line expected_lines[$];

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    function automatic longint unsigned euclid_gcd(longint unsigned p, longint unsigned q);
        longint unsigned r;
        while (q != 0) begin
            r = p % q;
            p = q;
            q = r;
        end
        return p;
    endfunction

    function automatic longint unsigned magnitude(longint v);
        return (v < 0) ? longint'(-v) : longint'(v);
    endfunction

    // Line through the two points, divided by the common gcd, first nonzero of (a,b) positive
    function automatic t_line canon_line(logic signed [CW-1:0] x1, logic signed [CW-1:0] y1,
                                         logic signed [CW-1:0] x2, logic signed [CW-1:0] y2);
        longint          ca, cb, cc, g_s;
        longint unsigned g;
        t_line           r;
        ca = longint'(y1) - longint'(y2);
        cb = longint'(x2) - longint'(x1);
        cc = longint'(x1) * longint'(y2) - longint'(x2) * longint'(y1);
        g  = euclid_gcd(magnitude(ca), euclid_gcd(magnitude(cb), magnitude(cc)));
        r.x1 = x1;
        r.y1 = y1;
        r.x2 = x2;
        r.y2 = y2;
        if (g == 0) begin
            // coincident points
            r.a     = '0;
            r.b     = '0;
            r.c     = '0;
            r.degen = 1'b1;
        end else begin
            g_s = longint'(g);
            ca  = ca / g_s;
            cb  = cb / g_s;
            cc  = cc / g_s;
            if (ca < 0 || (ca == 0 && cb < 0)) begin
                ca = -ca;
                cb = -cb;
                cc = -cc;
            end
            r.a     = ca[A_W-1:0];
            r.b     = cb[B_W-1:0];
            r.c     = cc[C_W-1:0];
            r.degen = 1'b0;
        end
        return r;
    endfunction

    // One line per mismatch, and count it
    task automatic report_mismatch(input string msg);
        $display("%0t ns: MISMATCH %s", $time, msg);
        o_fail_count++;
    endtask

    // Watch both channels; results are checked before new items are queued
    always @(posedge i_clk) begin : watch
        t_line want;
        if (i_rst_n) begin
            if (i_out_valid && i_out_ready) begin
                if (expected_lines.size() == 0) begin
                    report_mismatch($sformatf(
                        "result a=%0d b=%0d c=%0d deg=%0b with no item pending",
                        i_line_a, i_line_b, i_line_c, i_degenerate));
                end else begin
                    want = expected_lines.pop_front();
                    if (i_line_a !== want.a)
                        report_mismatch($sformatf("(%0d,%0d)-(%0d,%0d) line_a got %0d want %0d",
                            want.x1, want.y1, want.x2, want.y2, i_line_a, want.a));
                    if (i_line_b !== want.b)
                        report_mismatch($sformatf("(%0d,%0d)-(%0d,%0d) line_b got %0d want %0d",
                            want.x1, want.y1, want.x2, want.y2, i_line_b, want.b));
                    if (i_line_c !== want.c)
                        report_mismatch($sformatf("(%0d,%0d)-(%0d,%0d) line_c got %0d want %0d",
                            want.x1, want.y1, want.x2, want.y2, i_line_c, want.c));
                    if (i_degenerate !== want.degen)
                        report_mismatch($sformatf(
                            "(%0d,%0d)-(%0d,%0d) degenerate got %0b want %0b",
                            want.x1, want.y1, want.x2, want.y2, i_degenerate, want.degen));
                end
            end
            if (i_in_valid && i_in_ready)
                expected_lines.insert(expected_lines.size(),
                    canon_line(i_first_x, i_first_y, i_second_x, i_second_y));
            o_pending = expected_lines.size();
        end
    end

endmodule

### bench/tb.sv
`timescale 1ns / 100ps

module tb;
    import lftp_pkg::*;

    localparam int CW = COORD_BITS;
    localparam int ITEMS_PER_PHASE = 320;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_ready;
    logic signed [CW-1:0] first_x;
    logic signed [CW-1:0] first_y;
    logic signed [CW-1:0] second_x;
    logic signed [CW-1:0] second_y;
    logic                 o_out_valid;
    logic                 i_out_ready;
    logic [A_W-1:0]       line_a;
    logic signed [B_W-1:0] line_b;
    logic signed [C_W-1:0] line_c;
    logic                 degenerate;
    int                   fail_count;
    int                   pending;

    // Percent chance per cycle that the sender idles / the receiver stalls
    int idle_pct;
    int stall_pct;

    line_from_two_points_canonical_core dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_first_x    (first_x),
        .i_first_y    (first_y),
        .i_second_x   (second_x),
        .i_second_y   (second_y),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_line_a     (line_a),
        .o_line_b     (line_b),
        .o_line_c     (line_c),
        .o_degenerate (degenerate)
    );

    line_canon_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_ready   (o_in_ready),
        .i_first_x    (first_x),
        .i_first_y    (first_y),
        .i_second_x   (second_x),
        .i_second_y   (second_y),
        .i_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .i_line_a     (line_a),
        .i_line_b     (line_b),
        .i_line_c     (line_c),
        .i_degenerate (degenerate),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Run limit
    initial begin
        #20_000_000;
        $display("Verification failed");
        $finish;
    end

    // Receiver: random stalls, redrawn every falling edge
    initial begin
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            i_out_ready = ($urandom_range(99) >= stall_pct);
        end
    end

    // Present one point pair and hold it until accepted; called at a falling edge
    task automatic send_points(input int x1, input int y1, input int x2, input int y2);
        while ($urandom_range(99) < idle_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        first_x    = CW'(x1);
        first_y    = CW'(y1);
        second_x   = CW'(x2);
        second_y   = CW'(y2);
        do @(posedge i_clk); while (!o_in_ready);
        @(negedge i_clk);
    endtask

    function automatic logic signed [CW-1:0] extreme_coord();
        case ($urandom_range(6))
            0: return CW'(-32768);
            1: return CW'(-32767);
            2: return CW'(-1);
            3: return CW'(0);
            4: return CW'(1);
            5: return CW'(32766);
            default: return CW'(32767);
        endcase
    endfunction

    // Random point pair from a mix of shapes
    task automatic send_random_pair();
        logic signed [CW-1:0] x1, y1, x2, y2;
        int m;
        x1 = CW'($urandom);
        y1 = CW'($urandom);
        x2 = CW'($urandom);
        y2 = CW'($urandom);
        case ($urandom_range(9))
            4: begin
                // coincident points
                x2 = x1;
                y2 = y1;
            end
            5: begin
                // shared scale factor, so the gcd is large
                m  = $urandom_range(1, 2000);
                x1 = CW'(m * (int'($urandom_range(32)) - 16));
                y1 = CW'(m * (int'($urandom_range(32)) - 16));
                x2 = CW'(m * (int'($urandom_range(32)) - 16));
                y2 = CW'(m * (int'($urandom_range(32)) - 16));
            end
            6: begin
                // horizontal or vertical line
                if ($urandom_range(1)) y2 = y1;
                else                   x2 = x1;
            end
            7: begin
                x1 = extreme_coord();
                y1 = extreme_coord();
                x2 = extreme_coord();
                y2 = extreme_coord();
            end
            8: begin
                x1 = CW'(int'($urandom_range(16)) - 8);
                y1 = CW'(int'($urandom_range(16)) - 8);
                x2 = CW'(int'($urandom_range(16)) - 8);
                y2 = CW'(int'($urandom_range(16)) - 8);
            end
            9: begin
                // line through the origin
                x1 = '0;
                y1 = '0;
            end
            default: ;
        endcase
        send_points(int'(x1), int'(y1), int'(x2), int'(y2));
    endtask

    // Stimulus and verdict
    initial begin
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        first_x    = '0;
        first_y    = '0;
        second_x   = '0;
        second_y   = '0;
        idle_pct   = 0;
        stall_pct  = 0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: extremes, degenerate, axis-parallel lines, sign flips, big gcd
        send_points(0, 0, 0, 0);
        send_points(-32768, -32768, -32768, -32768);
        send_points(32767, 32767, 32767, 32767);
        send_points(-32768, -32768, 32767, 32767);
        send_points(-32768, 32767, 32767, -32768);
        send_points(32767, -32768, -32768, 32767);
        send_points(-32768, 32767, 32767, 32767);
        send_points(32767, -32768, -32768, -32768);
        send_points(-32768, -32768, -32768, 32767);
        send_points(32767, 32767, 32767, -32768);
        send_points(5, 3, -7, 3);
        send_points(-7, 3, 5, 3);
        send_points(4, -9, 4, 11);
        send_points(4, 11, 4, -9);
        send_points(0, 0, 30000, 30000);
        send_points(1, 2, 3, 4);
        send_points(3, 4, 1, 2);
        send_points(-1, -1, 1, 1);
        send_points(32767, 0, 0, 32767);
        send_points(-32768, 0, 0, -32768);
        send_points(-32767, 32766, 32766, -32767);
        send_points(12345, -6789, 12345, -6789);

        // Random phases: no idling, sender idle, receiver stall, both
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 71; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 71; end
                default: begin idle_pct = 23; stall_pct = 23; end
            endcase
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
                send_random_pair();
        end
        i_in_valid = 1'b0;

        // Drain
        while (pending != 0) @(negedge i_clk);
        repeat (250) @(negedge i_clk);

        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

### files.f
+incdir+rtl
rtl/lftp_pkg.sv
rtl/lftp_ctrl.sv
rtl/lftp_dp.sv
rtl/line_from_two_points_canonical_core.sv
bench/line_canon_checker.sv
bench/tb.sv
